FILE: sv/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("check failed");
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("check failed");
`endif

FILE: sv/vru_pkg.sv
// Types and constants of the vector rotation unit.
package vru_pkg;
	localparam int VW = 32;
	localparam int AW = 16;
	localparam int CW = 34;
	localparam int MW = 32;

	typedef enum logic [1:0] {
		OP_EULER = 2'd0,
		OP_ROT_X = 2'd1,
		OP_ROT_Y = 2'd2,
		OP_ROT_Z = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]          opcode;
		logic signed [VW-1:0] vec_x;
		logic signed [VW-1:0] vec_y;
		logic signed [VW-1:0] vec_z;
		logic [AW-1:0]       angle_theta;
		logic [AW-1:0]       angle_phi;
		logic [AW-1:0]       angle_psi;
	} in_item_t;

	typedef struct packed {
		logic signed [VW-1:0] out_x;
		logic signed [VW-1:0] out_y;
		logic signed [VW-1:0] out_z;
		logic                saturated;
	} out_item_t;

	localparam logic signed [CW-1:0] Q30_ONE = CW'(64'sd1073741824);
	localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(64'sd652032874);

	function automatic logic [31:0] atan_lut(input int i);
		logic [31:0] t [32];
		t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
			32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
			32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
			32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
			32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
			32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
			32'h00000000, 32'h00000000};
		return t[i];
	endfunction

	// Q30 product rounded half up with floor.
	function automatic logic signed [MW-1:0] mul_q30(input logic signed [MW-1:0] a,
		input logic signed [MW-1:0] b);
		logic signed [2*MW-1:0] p;
		p = a * b + 64'sd536870912;
		return MW'(p >>> 30);
	endfunction
endpackage

FILE: sv/vru_fifo.sv
// Short queue between the front and back parts.
module vru_fifo import vru_pkg::*; #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_valid,
	output logic         wr_stall,
	input  logic [W-1:0] wr_data,
	output logic         rd_valid,
	input  logic         rd_stall,
	output logic [W-1:0] rd_data
);
	logic [W-1:0] mem_q [2];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;
	logic         wr, rd;

	assign wr_stall = (cnt_q == 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = mem_q[rp_q];
	assign wr = wr_valid && !wr_stall;
	assign rd = rd_valid && !rd_stall;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end
endmodule

FILE: sv/vru_front.sv
// Front part: CORDIC sine and cosine for the three angles, pipelined.
module vru_front import vru_pkg::*; #(
	parameter int STAGES = 16,
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  in_item_t      in_item,
	output logic          out_valid,
	output logic [DW-1:0] out_data
);
	localparam int N = (STAGES > 32) ? 32 : STAGES;

	logic signed [CW-1:0] x_s1 [N+1][3];
	logic signed [CW-1:0] y_s1 [N+1][3];
	logic signed [CW-1:0] z_s1 [N+1][3];
	logic [1:0]           quad_s1 [N+1][3];
	in_item_t             item_s1 [N+1];
	logic                 vld_s1 [N+1];
	logic [AW-1:0]        ang [3];

	assign ang[0] = in_item.angle_theta;
	assign ang[1] = in_item.angle_phi;
	assign ang[2] = in_item.angle_psi;

	always_comb begin
		logic [31:0] a32;
		for (int k = 0; k < 3; k++) begin
			a32 = {ang[k], {(32-AW){1'b0}}};
			quad_s1[0][k] = a32[31:30];
			x_s1[0][k] = CORDIC_GAIN;
			y_s1[0][k] = '0;
			z_s1[0][k] = CW'({2'b00, a32[29:0]});
		end
		item_s1[0] = in_item;
		vld_s1[0] = in_valid;
	end

	for (genvar i = 0; i < N; i++) begin : g_st
		always_ff @(posedge clk) begin
			if (en) begin
				item_s1[i+1] <= item_s1[i];
				for (int k = 0; k < 3; k++) begin
					quad_s1[i+1][k] <= quad_s1[i][k];
					if (!z_s1[i][k][CW-1]) begin
						x_s1[i+1][k] <= x_s1[i][k] - (y_s1[i][k] >>> i);
						y_s1[i+1][k] <= y_s1[i][k] + (x_s1[i][k] >>> i);
						z_s1[i+1][k] <= z_s1[i][k] - CW'(atan_lut(i));
					end else begin
						x_s1[i+1][k] <= x_s1[i][k] + (y_s1[i][k] >>> i);
						y_s1[i+1][k] <= y_s1[i][k] - (x_s1[i][k] >>> i);
						z_s1[i+1][k] <= z_s1[i][k] + CW'(atan_lut(i));
					end
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s1[i+1] <= 1'b0;
			else if (en) vld_s1[i+1] <= vld_s1[i];
		end
	end

	function automatic logic signed [MW-1:0] clamp1(input logic signed [CW-1:0] v);
		if (v > Q30_ONE) return MW'(Q30_ONE);
		if (v < -Q30_ONE) return MW'(-Q30_ONE);
		return MW'(v);
	endfunction

	logic signed [MW-1:0] c [3], s [3];
	always_comb begin
		logic signed [MW-1:0] x, y;
		for (int k = 0; k < 3; k++) begin
			x = clamp1(x_s1[N][k]);
			y = clamp1(y_s1[N][k]);
			case (quad_s1[N][k])
				2'd0: begin c[k] = x; s[k] = y; end
				2'd1: begin c[k] = -y; s[k] = x; end
				2'd2: begin c[k] = -x; s[k] = -y; end
				default: begin c[k] = y; s[k] = -x; end
			endcase
		end
	end

	assign out_valid = vld_s1[N];
	assign out_data = DW'({item_s1[N].opcode, item_s1[N].vec_x, item_s1[N].vec_y,
		item_s1[N].vec_z, c[0], s[0], c[1], s[1], c[2], s[2]});
endmodule

FILE: sv/vru_back.sv
// Back part: matrix build, row products, rounding and saturation.
module vru_back import vru_pkg::*; #(
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [DW-1:0] in_data,
	output logic          out_valid,
	output out_item_t     out_item
);
	logic [1:0] op;
	logic signed [VW-1:0] vx, vy, vz;
	logic signed [MW-1:0] ct, st, cp, sp, cs, ss;
	assign {op, vx, vy, vz, ct, st, cp, sp, cs, ss} = in_data[2+3*VW+6*MW-1:0];

	// Stage 1: t, u and the single products.
	logic [1:0] op_s1;
	logic signed [VW-1:0] v_s1 [3];
	logic signed [MW-1:0] ct_s1, st_s1, cp_s1, sp_s1, cs_s1, ss_s1, t_s1, u_s1;
	logic v1_s1, v1_s2, v1_s3, v1_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= op;
			v_s1 <= '{vx, vy, vz};
			ct_s1 <= ct; st_s1 <= st; cp_s1 <= cp; sp_s1 <= sp;
			cs_s1 <= cs; ss_s1 <= ss;
			t_s1 <= mul_q30(ct, ss);
			u_s1 <= mul_q30(ct, cs);
		end
	end

	// Stage 2: matrix entries.
	logic signed [MW-1:0] m_s2 [9];
	logic signed [VW-1:0] v_s2 [3];
	always_ff @(posedge clk) begin
		logic signed [MW-1:0] m [9];
		if (en) begin
			v_s2 <= v_s1;
			for (int k = 0; k < 9; k++) m[k] = '0;
			unique case (op_t'(op_s1))
				OP_EULER: begin
					m[0] = mul_q30(cp_s1, cs_s1) - mul_q30(sp_s1, t_s1);
					m[1] = -mul_q30(cp_s1, ss_s1) - mul_q30(sp_s1, u_s1);
					m[2] = mul_q30(st_s1, sp_s1);
					m[3] = mul_q30(sp_s1, cs_s1) + mul_q30(cp_s1, t_s1);
					m[4] = -mul_q30(sp_s1, ss_s1) + mul_q30(cp_s1, u_s1);
					m[5] = -mul_q30(st_s1, cp_s1);
					m[6] = mul_q30(st_s1, ss_s1);
					m[7] = mul_q30(st_s1, cs_s1);
					m[8] = ct_s1;
				end
				OP_ROT_X: begin
					m[0] = MW'(Q30_ONE);
					m[4] = ct_s1; m[5] = -st_s1;
					m[7] = st_s1; m[8] = ct_s1;
				end
				OP_ROT_Y: begin
					m[0] = ct_s1; m[2] = st_s1;
					m[4] = MW'(Q30_ONE);
					m[6] = -st_s1; m[8] = ct_s1;
				end
				default: begin
					m[0] = ct_s1; m[1] = -st_s1;
					m[3] = st_s1; m[4] = ct_s1;
					m[8] = MW'(Q30_ONE);
				end
			endcase
			m_s2 <= m;
		end
	end

	// Stage 3: the nine entry by component products.
	localparam int PW = MW + VW;
	logic signed [PW-1:0] p_s3 [9];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) p_s3[k] <= m_s2[k] * v_s2[k % 3];
		end
	end

	// Stage 4: row sums, rounding and clipping.
	localparam int SW = PW + 2;
	localparam logic signed [SW-1:0] VMAX = SW'((65'sd1 <<< (VW-1)) - 1);
	localparam logic signed [SW-1:0] VMIN = -VMAX - 1;
	out_item_t res_s4;
	always_ff @(posedge clk) begin
		logic signed [SW-1:0] sum;
		logic signed [VW-1:0] r [3];
		logic sat;
		if (en) begin
			sat = 1'b0;
			for (int k = 0; k < 3; k++) begin
				sum = SW'(p_s3[3*k]) + SW'(p_s3[3*k+1]) + SW'(p_s3[3*k+2])
					+ SW'(64'sd536870912);
				sum = sum >>> 30;
				if (sum > VMAX) begin r[k] = VW'(VMAX); sat = 1'b1; end
				else if (sum < VMIN) begin r[k] = VW'(VMIN); sat = 1'b1; end
				else r[k] = VW'(sum);
			end
			res_s4 <= '{out_x: r[0], out_y: r[1], out_z: r[2], saturated: sat};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0; v1_s2 <= 1'b0; v1_s3 <= 1'b0; v1_s4 <= 1'b0;
		end else if (en) begin
			v1_s1 <= in_valid; v1_s2 <= v1_s1; v1_s3 <= v1_s2; v1_s4 <= v1_s3;
		end
	end

	assign out_valid = v1_s4;
	assign out_item = res_s4;
endmodule

FILE: sv/vector_rotation_unit.sv
// Top level of the vector rotation unit.
//  channel | direction | payload    | handshake
//  in      | input     | in_item_t  | in_valid / in_stall
//  out     | output    | out_item_t | out_valid / out_stall
// One vector per cycle while neither out_stall nor a full queue holds the flow; the path
// is min(CORDIC_STAGES, 32) front stages, the queue and four back stages.
// Reset clears only valid flags, queue pointers and the queue count.
// The front holds only while its last stage waits on a full queue; the back holds
// while its result waits on out_stall.
module vector_rotation_unit import vru_pkg::*; #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);
	localparam int DW = 2 + 3*VW + 6*MW;

	logic          f_valid, q_stall, q_valid, b_en, f_en, b_valid;
	logic [DW-1:0] f_data, q_data;

	// Front advances unless its last stage holds an item the queue refuses.
	assign f_en = !(f_valid && q_stall);
	assign in_stall = !f_en;

	vru_front #(.STAGES(CORDIC_STAGES), .DW(DW)) u_front (
		.clk, .arst_n, .en(f_en), .in_valid, .in_item,
		.out_valid(f_valid), .out_data(f_data)
	);

	vru_fifo #(.W(DW)) u_fifo (
		.clk, .arst_n, .wr_valid(f_valid), .wr_stall(q_stall), .wr_data(f_data),
		.rd_valid(q_valid), .rd_stall(!b_en), .rd_data(q_data)
	);

	assign b_en = !(b_valid && out_stall);

	vru_back #(.DW(DW)) u_back (
		.clk, .arst_n, .en(b_en), .in_valid(q_valid), .in_data(q_data),
		.out_valid(b_valid), .out_item
	);

	assign out_valid = b_valid;
endmodule

FILE: sv/vru_checker.sv
// Port-level checks for the vector rotation unit.
`include "assert_macros.svh"
module vru_checker import vru_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_item
);
	localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
	localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

	logic clipped;

	// A flagged result has at least one component at a range limit.
	assign clipped = (out_item.out_x == VMAX) || (out_item.out_x == VMIN)
		|| (out_item.out_y == VMAX) || (out_item.out_y == VMIN)
		|| (out_item.out_z == VMAX) || (out_item.out_z == VMIN);

	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_item))
	`CHK_IMPL(a_stall_only_busy, clk, arst_n, in_stall, out_valid || $past(out_valid))
	`CHK_IMPL(a_sat_clip, clk, arst_n, out_valid && out_item.saturated, clipped)
endmodule

bind vector_rotation_unit vru_checker u_chk (.*);
